FILE: rtl/core/ssfa_pkg.sv
`timescale 1ns / 1ps
package ssfa_pkg;

   localparam int MAX_VECTORS = 256;
   localparam int VEC_AW      = 8;
   localparam int VEC_CW      = VEC_AW + 1;
   localparam int MAX_SHELLS  = 64;
   localparam int SHELL_AW    = 6;
   localparam int SHELL_CW    = SHELL_AW + 1;
   localparam int TRIG_DEPTH  = 1024;
   localparam int TRIG_AW     = 10;
   localparam int QTR_AW      = TRIG_AW - 2;
   localparam int QUARTER     = TRIG_DEPTH / 4;
   localparam int SUM_W       = 28;
   localparam int TERM_W      = 16;
   localparam int WAVE_W      = 6;
   localparam int POS_W       = 16;
   localparam int ACC_W       = 64;
   localparam int WAVE_REC_W  = 3 * WAVE_W + SHELL_AW;
   localparam int SUM_REC_W   = 2 * SUM_W;
   localparam int ACC_REC_W   = ACC_W + 1;

   typedef enum logic [1:0] {
      MODE_LOAD     = 2'd0,
      MODE_PARTICLE = 2'd1,
      MODE_READ     = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_ACTIVE_VECTORS = 1'b0,
      CSR_SHELL_COUNT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      mode_type                   mode;
      logic [VEC_AW-1:0]          vector_index;
      logic [SHELL_AW-1:0]        shell_index;
      logic signed [WAVE_W-1:0]   wave_x;
      logic signed [WAVE_W-1:0]   wave_y;
      logic signed [WAVE_W-1:0]   wave_z;
      logic [POS_W-1:0]           pos_x;
      logic [POS_W-1:0]           pos_y;
      logic [POS_W-1:0]           pos_z;
      logic                       last_particle;
   } cmd_type;

   typedef struct packed {
      logic [ACC_W-1:0] shell_sum;
      logic [8:0]       vector_count;
      logic [15:0]      frame_count;
      logic             sum_saturated;
   } rsp_type;

   // sine of j quarter-table steps, Q.14, odd polynomial in Q.30
   function automatic logic [14:0] quarter_sine(int unsigned j);
      longint unsigned t;
      longint unsigned t2;
      longint unsigned acc;
      longint unsigned v;
      t   = 64'(j) << (32 - TRIG_AW);
      t2  = (t * t) >> 30;
      acc = 64'd172272;
      acc = 64'd5026991 - ((acc * t2) >> 30);
      acc = 64'd85569306 - ((acc * t2) >> 30);
      acc = 64'd693598668 - ((acc * t2) >> 30);
      acc = 64'd1686629713 - ((acc * t2) >> 30);
      v   = (acc * t) >> 30;
      v   = (v + 64'd32768) >> 16;
      if (v > 64'd16384) begin
         v = 64'd16384;
      end
      return 15'(v);
   endfunction

   typedef logic [14:0] sine_lut_type [QUARTER+1];

   function automatic sine_lut_type build_sine_lut();
      sine_lut_type lut;
      int unsigned  j;
      for (j = 0; j <= QUARTER; j++) begin
         lut[j] = quarter_sine(j);
      end
      return lut;
   endfunction

   localparam sine_lut_type SINE_LUT = build_sine_lut();

endpackage

FILE: rtl/core/ssfa_ram.sv
`timescale 1ns / 1ps
module ssfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: rtl/core/ssfa_fifo.sv
`timescale 1ns / 1ps
module ssfa_fifo #(
   parameter type T = logic [7:0]
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     push_data,
   output logic full,
   input  logic pop,
   output T     head,
   output logic empty
);
   T           slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in    = do_push ? !wr_ff : wr_ff;
      rd_in    = do_pop ? !rd_ff : rd_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule

FILE: rtl/core/ssfa_front.sv
`timescale 1ns / 1ps
module ssfa_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  ssfa_pkg::cmd_type   req_cmd,
   output ssfa_pkg::cmd_type   cmd,
   output logic                cmd_valid,
   input  logic                cmd_pop
);
   import ssfa_pkg::*;

   cmd_type cmd_clean;
   logic    cmd_empty;

   // pull the one out-of-range code back to the negative limit
   function automatic logic signed [WAVE_W-1:0] clamp_wave(logic signed [WAVE_W-1:0] k);
      logic signed [WAVE_W-1:0] r;
      r = k;
      if (k == {1'b1, {(WAVE_W-1){1'b0}}}) begin
         r = {1'b1, {(WAVE_W-2){1'b0}}, 1'b1};
      end
      return r;
   endfunction

   always_comb begin
      cmd_clean        = req_cmd;
      cmd_clean.wave_x = clamp_wave(req_cmd.wave_x);
      cmd_clean.wave_y = clamp_wave(req_cmd.wave_y);
      cmd_clean.wave_z = clamp_wave(req_cmd.wave_z);
   end

   ssfa_fifo #(.T(cmd_type)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_clean),
      .full      (req_full),
      .pop       (cmd_pop),
      .head      (cmd),
      .empty     (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;
endmodule

FILE: rtl/core/ssfa_engine.sv
`timescale 1ns / 1ps
module ssfa_engine (
   input  logic              clock,
   input  logic              reset,
   input  ssfa_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  logic [8:0]        active_vectors,
   input  logic [6:0]        shell_count,
   output ssfa_pkg::rsp_type rsp,
   output logic              rsp_push,
   input  logic              rsp_full
);
   import ssfa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_PASS, S_DRAIN, S_FOLD_ISSUE, S_FOLD_ABS, S_FOLD_SQ, S_FOLD_Q,
      S_FOLD_ACC, S_FOLD_END, S_COUNT, S_COUNT_LAST, S_REPLY
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cur_ff, cur_in;
   logic [VEC_CW-1:0]       e_ff, e_in;
   logic [MAX_VECTORS-1:0]  sum_ok_ff, sum_ok_in;
   logic [MAX_SHELLS-1:0]   acc_ok_ff, acc_ok_in;
   logic [15:0]             frames_ff, frames_in;
   logic [8:0]              count_ff, count_in;
   logic                    cnt_v_ff, cnt_v_in;

   logic [VEC_CW-1:0]       n_used, last_e;
   logic [SHELL_CW-1:0]     ns_used;
   logic                    last_issue;

   logic [WAVE_REC_W-1:0]   wave_rd;
   logic [SUM_REC_W-1:0]    sum_rd;
   logic [ACC_REC_W-1:0]    acc_rd;
   logic                    wave_we;
   logic [SHELL_AW-1:0]     acc_raddr;
   logic                    acc_we;
   logic [ACC_REC_W-1:0]    acc_wdata;
   logic                    sum_we;
   logic [SUM_REC_W-1:0]    sum_wdata;

   logic [SHELL_AW-1:0]     rd_tag;
   logic [WAVE_W-1:0]       rd_kx, rd_ky, rd_kz;
   logic signed [SUM_W-1:0] rd_cos, rd_sin;

   // particle pipeline
   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic [VEC_AW-1:0]       e1_ff, e2_ff, e3_ff, e4_ff;
   logic [POS_W-1:0]        px_ff, py_ff, pz_ff;
   logic [15:0]             prx_ff, pry_ff, prz_ff;
   logic signed [SUM_W-1:0] c2_ff, s2_ff, c3_ff, s3_ff, c4_ff, s4_ff;
   logic [TRIG_AW-1:0]      sidx_ff;
   logic signed [TERM_W-1:0] st_ff, ct_ff;
   logic [15:0]             phase;

   // fold datapath
   logic [SHELL_AW-1:0]     tag_ff;
   logic [SUM_W-1:0]        cm_ff, sm_ff;
   logic [2*SUM_W-1:0]      sqc_ff, sqs_ff;
   logic [ACC_W-1:0]        old_ff;
   logic                    old_sat_ff;
   logic [2*SUM_W-20:0]     q_ff;
   logic [ACC_W:0]          acc_sum;

   always_comb begin
      n_used     = (active_vectors > 9'(MAX_VECTORS)) ? VEC_CW'(MAX_VECTORS)
                                                      : VEC_CW'(active_vectors);
      ns_used    = (shell_count > 7'(MAX_SHELLS)) ? SHELL_CW'(MAX_SHELLS)
                                                  : SHELL_CW'(shell_count);
      last_e     = n_used - 1'b1;
      last_issue = (e_ff == last_e);
   end

   assign {rd_tag, rd_kz, rd_ky, rd_kx} = wave_rd;
   assign {rd_cos, rd_sin}              = sum_rd;

   ssfa_ram #(.WIDTH(WAVE_REC_W), .DEPTH(MAX_VECTORS)) u_wave_ram (
      .clock (clock),
      .we    (wave_we),
      .waddr (cmd.vector_index),
      .wdata ({cmd.shell_index, cmd.wave_z, cmd.wave_y, cmd.wave_x}),
      .raddr (e_ff[VEC_AW-1:0]),
      .rdata (wave_rd)
   );

   ssfa_ram #(.WIDTH(SUM_REC_W), .DEPTH(MAX_VECTORS)) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .waddr (e4_ff),
      .wdata (sum_wdata),
      .raddr (e_ff[VEC_AW-1:0]),
      .rdata (sum_rd)
   );

   ssfa_ram #(.WIDTH(ACC_REC_W), .DEPTH(MAX_SHELLS)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (tag_ff),
      .wdata (acc_wdata),
      .raddr (acc_raddr),
      .rdata (acc_rd)
   );

   function automatic logic signed [TERM_W-1:0] sine_of(logic [TRIG_AW-1:0] idx);
      logic [QTR_AW:0]          j;
      logic signed [TERM_W-1:0] v;
      j = idx[TRIG_AW-2] ? (QTR_AW+1)'(QUARTER) - {1'b0, idx[QTR_AW-1:0]}
                         : {1'b0, idx[QTR_AW-1:0]};
      v = TERM_W'(SINE_LUT[j]);
      return idx[TRIG_AW-1] ? -v : v;
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] s,
                                                       logic signed [TERM_W-1:0] d);
      logic signed [SUM_W:0] r;
      logic signed [SUM_W-1:0] o;
      r = {s[SUM_W-1], s} + (SUM_W+1)'(d);
      o = r[SUM_W-1:0];
      if (r[SUM_W] != r[SUM_W-1]) begin
         o = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return o;
   endfunction

   // particle pipeline: read, multiply, phase, table, accumulate
   assign phase     = prx_ff + pry_ff + prz_ff;
   assign sum_we    = v4_ff;
   assign sum_wdata = {sat_add(c4_ff, ct_ff), sat_add(s4_ff, st_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == S_PASS);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      e1_ff   <= e_ff[VEC_AW-1:0];
      prx_ff  <= {{(16-WAVE_W){rd_kx[WAVE_W-1]}}, rd_kx} * px_ff;
      pry_ff  <= {{(16-WAVE_W){rd_ky[WAVE_W-1]}}, rd_ky} * py_ff;
      prz_ff  <= {{(16-WAVE_W){rd_kz[WAVE_W-1]}}, rd_kz} * pz_ff;
      c2_ff   <= sum_ok_ff[e1_ff] ? rd_cos : '0;
      s2_ff   <= sum_ok_ff[e1_ff] ? rd_sin : '0;
      e2_ff   <= e1_ff;
      sidx_ff <= phase[15 -: TRIG_AW];
      c3_ff   <= c2_ff;
      s3_ff   <= s2_ff;
      e3_ff   <= e2_ff;
      st_ff   <= sine_of(sidx_ff);
      ct_ff   <= sine_of(sidx_ff + TRIG_AW'(QUARTER));
      c4_ff   <= c3_ff;
      s4_ff   <= s3_ff;
      e4_ff   <= e3_ff;
   end

   // fold datapath
   assign acc_sum   = {1'b0, old_ff} + (ACC_W+1)'(q_ff);
   assign acc_we    = (state_ff == S_FOLD_ACC) && ({1'b0, tag_ff} < ns_used);
   assign acc_wdata = acc_sum[ACC_W] ? {1'b1, {ACC_W{1'b1}}}
                                     : {old_sat_ff, acc_sum[ACC_W-1:0]};
   assign acc_raddr = (state_ff == S_FOLD_ABS) ? rd_tag : cur_ff.shell_index;

   always_ff @(posedge clock) begin
      if (state_ff == S_FOLD_ABS) begin
         tag_ff <= rd_tag;
         cm_ff  <= SUM_W'(!sum_ok_ff[e_ff[VEC_AW-1:0]] ? '0 : rd_cos < 0 ? -rd_cos : rd_cos);
         sm_ff  <= SUM_W'(!sum_ok_ff[e_ff[VEC_AW-1:0]] ? '0 : rd_sin < 0 ? -rd_sin : rd_sin);
      end
      // hold the shell word read for this tag; the read port moves on after
      if (state_ff == S_FOLD_SQ) begin
         old_ff     <= acc_ok_ff[tag_ff] ? acc_rd[ACC_W-1:0] : '0;
         old_sat_ff <= acc_ok_ff[tag_ff] && acc_rd[ACC_W];
      end
      sqc_ff     <= cm_ff * cm_ff;
      sqs_ff     <= sm_ff * sm_ff;
      q_ff       <= (2*SUM_W-19)'(({1'b0, sqc_ff} + {1'b0, sqs_ff}) >> 20);
   end

   // sequencer
   assign cmd_pop  = cmd_valid && (state_ff == S_IDLE);
   assign wave_we  = cmd_pop && (cmd.mode == MODE_LOAD);
   assign rsp_push = (state_ff == S_REPLY) && !rsp_full;

   always_comb begin
      rsp.frame_count   = frames_ff;
      rsp.shell_sum     = '0;
      rsp.vector_count  = '0;
      rsp.sum_saturated = 1'b0;
      if ({1'b0, cur_ff.shell_index} < ns_used) begin
         rsp.shell_sum     = acc_ok_ff[cur_ff.shell_index] ? acc_rd[ACC_W-1:0] : '0;
         rsp.vector_count  = count_ff;
         rsp.sum_saturated = acc_ok_ff[cur_ff.shell_index] && acc_rd[ACC_W];
      end
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      e_in      = e_ff;
      sum_ok_in = sum_ok_ff;
      acc_ok_in = acc_ok_ff;
      frames_in = frames_ff;
      count_in  = count_ff;
      cnt_v_in  = 1'b0;
      if (v4_ff) begin
         sum_ok_in[e4_ff] = 1'b1;
      end
      unique case (state_ff)
         S_IDLE: begin
            e_in     = '0;
            count_in = '0;
            if (cmd_valid) begin
               cur_in = cmd;
               unique case (cmd.mode)
                  MODE_LOAD: begin
                     sum_ok_in[cmd.vector_index] = 1'b0;
                  end
                  MODE_CLEAR: begin
                     sum_ok_in = '0;
                     acc_ok_in = '0;
                     frames_in = '0;
                  end
                  MODE_PARTICLE: begin
                     if (n_used != '0) begin
                        state_in = S_PASS;
                     end else if (cmd.last_particle) begin
                        state_in = S_FOLD_END;
                     end
                  end
                  MODE_READ: begin
                     state_in = (n_used != '0) ? S_COUNT : S_COUNT_LAST;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PASS: begin
            e_in = e_ff + 1'b1;
            if (last_issue) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff && !v4_ff) begin
               e_in     = '0;
               state_in = cur_ff.last_particle ? S_FOLD_ISSUE : S_IDLE;
            end
         end
         S_FOLD_ISSUE: state_in = S_FOLD_ABS;
         S_FOLD_ABS:   state_in = S_FOLD_SQ;
         S_FOLD_SQ:    state_in = S_FOLD_Q;
         S_FOLD_Q:     state_in = S_FOLD_ACC;
         S_FOLD_ACC: begin
            if (acc_we) begin
               acc_ok_in[tag_ff] = 1'b1;
            end
            e_in     = e_ff + 1'b1;
            state_in = last_issue ? S_FOLD_END : S_FOLD_ISSUE;
         end
         S_FOLD_END: begin
            sum_ok_in = '0;
            if (frames_ff != 16'hFFFF) begin
               frames_in = frames_ff + 1'b1;
            end
            state_in = S_IDLE;
         end
         S_COUNT: begin
            cnt_v_in = 1'b1;
            e_in     = e_ff + 1'b1;
            if (cnt_v_ff && rd_tag == cur_ff.shell_index) begin
               count_in = count_ff + 1'b1;
            end
            if (last_issue) begin
               state_in = S_COUNT_LAST;
            end
         end
         S_COUNT_LAST: begin
            if (cnt_v_ff && rd_tag == cur_ff.shell_index) begin
               count_in = count_ff + 1'b1;
            end
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (!rsp_full) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         e_ff      <= '0;
         sum_ok_ff <= '0;
         acc_ok_ff <= '0;
         frames_ff <= '0;
         count_ff  <= '0;
         cnt_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         e_ff      <= e_in;
         sum_ok_ff <= sum_ok_in;
         acc_ok_ff <= acc_ok_in;
         frames_ff <= frames_in;
         count_ff  <= count_in;
         cnt_v_ff  <= cnt_v_in;
      end
      cur_ff <= cur_in;
      if (state_ff == S_IDLE && cmd_valid) begin
         px_ff <= cmd.pos_x;
         py_ff <= cmd.pos_y;
         pz_ff <= cmd.pos_z;
      end
   end

   a_cmd_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> state_ff == S_IDLE)
      else $error("command taken while busy");
   a_wb_in_pass: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (state_ff == S_PASS || state_ff == S_DRAIN))
      else $error("sum write-back outside particle pass");
   a_fold_after_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FOLD_ISSUE |-> !v1_ff && !v2_ff && !v3_ff && !v4_ff)
      else $error("fold started with particle pipeline busy");
   a_reply_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && rsp_full) |=> state_ff == S_REPLY)
      else $error("reply dropped under stall");
endmodule

FILE: rtl/core/static_structure_factor_accumulator.sv
`timescale 1ns / 1ps
// Shell-averaged static structure factor accumulator.
// Request queue (req_push / req_full): one beat per command. mode 0 loads a
// wave vector entry, mode 1 feeds one particle position, mode 2 reads a
// shell, mode 3 clears the accumulators. A beat is taken when push is high
// and full is low; a two-entry command queue decouples intake from the
// engine, so the next beats land while the engine works.
// Response queue (rsp_empty / rsp_pop): only mode 2 produces a beat; it sits
// in a two-entry result queue until popped, and a stalled receiver only
// blocks the engine once that queue is full.
// CSR port: csr_we writes active_vectors (index 0) or shell_count (index 1);
// write only while the block is idle.
// Work per command, with n active vectors: a particle streams one vector a
// cycle through the phase/sine pipeline, bound by the single sum RAM read
// port; a last particle adds a fold over the n vectors (serial
// read-modify-write of the shell accumulator RAM). A read does a tag scan
// over the n vectors for the vector count. Load and clear finish in idle.
// Reset: valid-bit flops zero the running sums and shell accumulators at
// once; no clearing pass. The vector table is undefined until loaded.
module static_structure_factor_accumulator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_vector_index,
   input  logic [5:0]         req_shell_index,
   input  logic signed [5:0]  req_wave_x,
   input  logic signed [5:0]  req_wave_y,
   input  logic signed [5:0]  req_wave_z,
   input  logic [15:0]        req_pos_x,
   input  logic [15:0]        req_pos_y,
   input  logic [15:0]        req_pos_z,
   input  logic               req_last_particle,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [63:0]        rsp_shell_sum,
   output logic [8:0]         rsp_vector_count,
   output logic [15:0]        rsp_frame_count,
   output logic               rsp_sum_saturated,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [8:0]         csr_wdata
);
   import ssfa_pkg::*;

   logic [8:0] active_vectors_ff;
   logic [6:0] shell_count_ff;
   cmd_type    req_cmd;
   cmd_type    cmd;
   logic       cmd_valid;
   logic       cmd_pop;
   rsp_type    rsp;
   logic       rsp_push;
   logic       rsp_full;
   rsp_type    rsp_head;

   // hold the two config registers; the engine reads them live
   always_ff @(posedge clock) begin
      if (reset) begin
         active_vectors_ff <= '0;
         shell_count_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ACTIVE_VECTORS: active_vectors_ff <= csr_wdata;
            CSR_SHELL_COUNT:    shell_count_ff    <= csr_wdata[6:0];
            default:            active_vectors_ff <= active_vectors_ff;
         endcase
      end
   end

   // pack the request beat
   always_comb begin
      req_cmd.mode          = mode_type'(req_mode);
      req_cmd.vector_index  = req_vector_index;
      req_cmd.shell_index   = req_shell_index;
      req_cmd.wave_x        = req_wave_x;
      req_cmd.wave_y        = req_wave_y;
      req_cmd.wave_z        = req_wave_z;
      req_cmd.pos_x         = req_pos_x;
      req_cmd.pos_y         = req_pos_y;
      req_cmd.pos_z         = req_pos_z;
      req_cmd.last_particle = req_last_particle;
   end

   ssfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_cmd   (req_cmd),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   ssfa_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop),
      .active_vectors (active_vectors_ff),
      .shell_count    (shell_count_ff),
      .rsp            (rsp),
      .rsp_push       (rsp_push),
      .rsp_full       (rsp_full)
   );

   // result queue: parts the engine from a stalled receiver
   ssfa_fifo #(.T(rsp_type)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .head      (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_shell_sum     = rsp_head.shell_sum;
   assign rsp_vector_count  = rsp_head.vector_count;
   assign rsp_frame_count   = rsp_head.frame_count;
   assign rsp_sum_saturated = rsp_head.sum_saturated;
endmodule

FILE: tb/sv/static_structure_factor_accumulator_tb.sv
`timescale 1ns / 1ps
module static_structure_factor_accumulator_tb;
   import ssfa_pkg::*;

   localparam int CYCLE_LIMIT  = 3000000;
   // covers the engine time for one command at 256 vectors: particle plus fold
   localparam int SETTLE_WAIT  = 4000;
   localparam int MISMATCH_MAX = 10;
   localparam int NUM_PHASES   = 8;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [1:0]        req_mode = '0;
   logic [7:0]        req_vector_index = '0;
   logic [5:0]        req_shell_index = '0;
   logic signed [5:0] req_wave_x = '0;
   logic signed [5:0] req_wave_y = '0;
   logic signed [5:0] req_wave_z = '0;
   logic [15:0]       req_pos_x = '0;
   logic [15:0]       req_pos_y = '0;
   logic [15:0]       req_pos_z = '0;
   logic              req_last_particle = 1'b0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [63:0]       rsp_shell_sum;
   logic [8:0]        rsp_vector_count;
   logic [15:0]       rsp_frame_count;
   logic              rsp_sum_saturated;
   logic              csr_we = 1'b0;
   logic [0:0]        csr_index = '0;
   logic [8:0]        csr_wdata = '0;

   static_structure_factor_accumulator u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // --------------------------------------------------------------------
   // Shadow of the block: wave table, running sums, shell accumulators
   // --------------------------------------------------------------------
   logic signed [5:0]  wave_kx [MAX_VECTORS];
   logic signed [5:0]  wave_ky [MAX_VECTORS];
   logic signed [5:0]  wave_kz [MAX_VECTORS];
   logic [5:0]         wave_tag [MAX_VECTORS];
   longint             cos_acc [MAX_VECTORS];
   longint             sin_acc [MAX_VECTORS];
   logic [63:0]        shell_total [MAX_SHELLS];
   logic               shell_sat [MAX_SHELLS];
   logic [15:0]        frames;
   logic [8:0]         active_vectors;
   logic [6:0]         shell_count;

   rsp_type shell_reads_due [$];
   int      mismatches = 0;
   longint  cycles = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;

   function automatic int vectors_in_use();
      return (active_vectors > MAX_VECTORS) ? MAX_VECTORS : int'(active_vectors);
   endfunction

   function automatic int shells_in_use();
      return (shell_count > MAX_SHELLS) ? MAX_SHELLS : int'(shell_count);
   endfunction

   // sine of t quarter turns (t in Q.30) as Q.14, odd polynomial
   function automatic int poly_sine(longint unsigned t);
      longint unsigned t2;
      longint unsigned c;
      longint unsigned v;
      t2 = (t * t) >> 30;
      c  = 172272;
      c  = 5026991 - ((c * t2) >> 30);
      c  = 85569306 - ((c * t2) >> 30);
      c  = 693598668 - ((c * t2) >> 30);
      c  = 1686629713 - ((c * t2) >> 30);
      v  = (c * t) >> 30;
      v  = (v + 32768) >> 16;
      return (v > 16384) ? 16384 : int'(v);
   endfunction

   // sine of an angle in 2^-32 turn, quadrants mirrored and negated
   function automatic int angle_sine(logic [31:0] ang);
      longint unsigned rem;
      int              mag;
      rem = ang[29:0];
      mag = poly_sine(ang[30] ? (64'd1 << 30) - rem : rem);
      return ang[31] ? -mag : mag;
   endfunction

   function automatic longint clamp_sum(longint s);
      if (s > 134217727) return 134217727;
      if (s < -134217728) return -134217728;
      return s;
   endfunction

   function automatic logic signed [5:0] clamp_wave(logic signed [5:0] k);
      return (k == -6'sd32) ? -6'sd31 : k;
   endfunction

   function automatic void clear_running_sums();
      for (int e = 0; e < MAX_VECTORS; e++) begin
         cos_acc[e] = 0;
         sin_acc[e] = 0;
      end
   endfunction

   function automatic void add_particle(cmd_type c);
      logic [31:0] phase_sum;
      logic [9:0]  step;
      logic [31:0] ang;
      for (int e = 0; e < vectors_in_use(); e++) begin
         phase_sum = wave_kx[e] * int'(c.pos_x) + wave_ky[e] * int'(c.pos_y)
                   + wave_kz[e] * int'(c.pos_z);
         step = phase_sum[15:6];
         ang  = {step, 22'd0};
         cos_acc[e] = clamp_sum(cos_acc[e] + angle_sine(ang + 32'h4000_0000));
         sin_acc[e] = clamp_sum(sin_acc[e] + angle_sine(ang));
      end
   endfunction

   function automatic void fold_frame();
      longint unsigned mag2;
      for (int e = 0; e < vectors_in_use(); e++) begin
         mag2 = longint'(cos_acc[e] * cos_acc[e] + sin_acc[e] * sin_acc[e]) >> 20;
         if (wave_tag[e] >= shells_in_use()) continue;
         if (shell_total[wave_tag[e]] > ~64'd0 - mag2) begin
            shell_total[wave_tag[e]] = ~64'd0;
            shell_sat[wave_tag[e]] = 1'b1;
         end else begin
            shell_total[wave_tag[e]] += mag2;
         end
      end
      clear_running_sums();
      if (frames != 16'hFFFF) frames++;
   endfunction

   // apply one accepted beat; return 1 with the shell readout for a read
   function automatic bit apply_command(cmd_type c, output rsp_type r);
      int cnt;
      r = '0;
      case (c.mode)
         MODE_LOAD: begin
            wave_kx[c.vector_index]  = clamp_wave(c.wave_x);
            wave_ky[c.vector_index]  = clamp_wave(c.wave_y);
            wave_kz[c.vector_index]  = clamp_wave(c.wave_z);
            wave_tag[c.vector_index] = c.shell_index;
            cos_acc[c.vector_index]  = 0;
            sin_acc[c.vector_index]  = 0;
         end
         MODE_PARTICLE: begin
            add_particle(c);
            if (c.last_particle) fold_frame();
         end
         MODE_CLEAR: begin
            for (int s = 0; s < MAX_SHELLS; s++) begin
               shell_total[s] = '0;
               shell_sat[s] = 1'b0;
            end
            clear_running_sums();
            frames = '0;
         end
         default: begin
            r.frame_count = frames;
            if (c.shell_index < shells_in_use()) begin
               cnt = 0;
               for (int e = 0; e < vectors_in_use(); e++) begin
                  if (wave_tag[e] == c.shell_index) cnt++;
               end
               r.shell_sum     = shell_total[c.shell_index];
               r.vector_count  = 9'(cnt);
               r.sum_saturated = shell_sat[c.shell_index];
            end
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // --------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------
   // hold push high across back-to-back beats; lower it only on an idle cycle
   task automatic send_beat(cmd_type c, bit typed_ok, rsp_type typed_rsp);
      rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push          <= 1'b1;
      req_mode          <= c.mode;
      req_vector_index  <= c.vector_index;
      req_shell_index   <= c.shell_index;
      req_wave_x        <= c.wave_x;
      req_wave_y        <= c.wave_y;
      req_wave_z        <= c.wave_z;
      req_pos_x         <= c.pos_x;
      req_pos_y         <= c.pos_y;
      req_pos_z         <= c.pos_z;
      req_last_particle <= c.last_particle;
      do @(posedge clock); while (req_full);
      if (apply_command(c, r)) shell_reads_due.push_back(typed_ok ? typed_rsp : r);
   endtask

   task automatic send(cmd_type c);
      send_beat(c, 1'b0, '0);
   endtask

   // drain outstanding reads, then give the engine time to finish silent work
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (shell_reads_due.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [8:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ACTIVE_VECTORS) active_vectors = val;
      else shell_count = val[6:0];
   endtask

   function automatic logic [15:0] rand_pos();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic cmd_type rand_cmd(mode_type m);
      cmd_type c;
      c.mode          = m;
      c.vector_index  = 8'($urandom);
      c.shell_index   = 6'($urandom);
      c.wave_x        = 6'($urandom);
      c.wave_y        = 6'($urandom);
      c.wave_z        = 6'($urandom);
      c.pos_x         = rand_pos();
      c.pos_y         = rand_pos();
      c.pos_z         = rand_pos();
      c.last_particle = 1'b0;
      return c;
   endfunction

   // read a shell, mostly one in use, sometimes beyond shell_count
   function automatic cmd_type rand_read();
      cmd_type c;
      c = rand_cmd(MODE_READ);
      if (shells_in_use() > 0 && $urandom_range(3) != 0) begin
         c.shell_index = 6'($urandom_range(shells_in_use() - 1));
      end
      return c;
   endfunction

   // loads keep tags mostly inside the shells in use so folds land
   function automatic cmd_type rand_load();
      cmd_type c;
      c = rand_cmd(MODE_LOAD);
      if (shells_in_use() > 0 && $urandom_range(3) != 0) begin
         c.shell_index = 6'($urandom_range(shells_in_use() - 1));
      end
      return c;
   endfunction

   // --------------------------------------------------------------------
   // Response side: random pop, compare against the oldest readout due
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (shell_reads_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_MAX)
               $display("unexpected beat: sum %0d count %0d frames %0d sat %0d",
                        rsp_shell_sum, rsp_vector_count, rsp_frame_count,
                        rsp_sum_saturated);
         end else begin
            want = shell_reads_due.pop_front();
            if (rsp_shell_sum !== want.shell_sum || rsp_vector_count !== want.vector_count
                || rsp_frame_count !== want.frame_count
                || rsp_sum_saturated !== want.sum_saturated) begin
               mismatches++;
               if (mismatches <= MISMATCH_MAX)
                  $display("readout mismatch: sum %0d/%0d count %0d/%0d frames %0d/%0d sat %0d/%0d",
                           want.shell_sum, rsp_shell_sum, want.vector_count,
                           rsp_vector_count, want.frame_count, rsp_frame_count,
                           want.sum_saturated, rsp_sum_saturated);
            end
         end
      end
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // --------------------------------------------------------------------
   // Directed rows: typed readouts only where they are obvious
   // --------------------------------------------------------------------
   typedef struct {
      cmd_type cmd;
      bit      typed;
      rsp_type want;
   } row_type;

   function automatic row_type mk_row(mode_type m, int vi, int sh, int kx, int ky, int kz,
                                      int pos, bit last, bit typed, int frames_want);
      row_type row;
      row.cmd = '{m, 8'(vi), 6'(sh), 6'(kx), 6'(ky), 6'(kz),
                  16'(pos), 16'(pos), 16'(pos), last};
      row.typed = typed;
      row.want = '0;
      row.want.frame_count = 16'(frames_want);
      return row;
   endfunction

   initial begin
      row_type rows [$];
      cmd_type c;
      int      phase_active [NUM_PHASES] = '{256, 8, 1, 511, 16, 3, 32, 0};
      int      phase_shells [NUM_PHASES] = '{64, 4, 1, 127, 0, 70, 2, 8};
      int      phase_items  [NUM_PHASES] = '{40, 90, 90, 40, 90, 90, 90, 90};
      int      sent;
      int      frame_len;

      for (int s = 0; s < MAX_SHELLS; s++) begin
         shell_total[s] = '0;
         shell_sat[s] = 1'b0;
      end
      clear_running_sums();
      frames = '0;
      active_vectors = '0;
      shell_count = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: no vectors, no shells
      rows.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0));
      rows.push_back(mk_row(MODE_READ, 0, 63, 0, 0, 0, 0, 0, 1, 0));
      rows.push_back(mk_row(MODE_PARTICLE, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      rows.push_back(mk_row(MODE_PARTICLE, 0, 0, 0, 0, 0, 'hFFFF, 1, 0, 0));
      rows.push_back(mk_row(MODE_READ, 0, 5, 0, 0, 0, 0, 0, 1, 2));
      // wave extremes; -32 clamps to -31
      rows.push_back(mk_row(MODE_LOAD, 0, 0, -32, -32, -32, 0, 0, 0, 0));
      rows.push_back(mk_row(MODE_LOAD, 255, 63, 31, 31, 31, 0, 0, 0, 0));
      rows.push_back(mk_row(MODE_LOAD, 1, 1, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk_row(MODE_LOAD, 2, 0, -31, 1, -1, 0, 0, 0, 0));
      rows.push_back(mk_row(MODE_PARTICLE, 0, 0, 0, 0, 0, 'h8000, 0, 0, 0));
      rows.push_back(mk_row(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0));
      foreach (rows[i]) send_beat(rows[i].cmd, rows[i].typed, rows[i].want);

      // fill the whole table so no active entry is ever unwritten
      for (int v = 0; v < MAX_VECTORS; v++) begin
         c = rand_cmd(MODE_LOAD);
         c.vector_index = 8'(v);
         send(c);
      end
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(CSR_ACTIVE_VECTORS, 9'(phase_active[p]));
         write_reg(CSR_SHELL_COUNT, 9'(phase_shells[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase

         // tight frames with random content and reads; some noise mixed in
         sent = 0;
         while (sent < phase_items[p]) begin
            case ($urandom_range(19))
               0: send(rand_load());
               1: send(rand_cmd(MODE_CLEAR));
               2, 3: send(rand_cmd(mode_type'($urandom_range(3))));
               default: begin
                  frame_len = $urandom_range(1, 4);
                  for (int k = 0; k < frame_len; k++) begin
                     c = rand_cmd(MODE_PARTICLE);
                     c.last_particle = (k == frame_len - 1);
                     send(c);
                  end
                  sent += frame_len;
                  send(rand_read());
                  if ($urandom_range(1)) begin
                     send(rand_read());
                     sent++;
                  end
               end
            endcase
            sent++;
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
